// File: hw/rtl/wsh_pkg.sv
// ----------------------------------------------------------------------------
// Windowed sample history package
// Types and constants that the history unit and its submodules share.
// ----------------------------------------------------------------------------
package wsh_pkg;

  localparam int TimeW  = 32;
  localparam int TempW  = 16;
  localparam int CountW = 9;
  localparam int InDataW  = 80;
  localparam int OutDataW = 96;

  typedef enum logic {
    OpAppend = 1'b0,
    OpQuery  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StWalk,
    StDivStart,
    StDivWait,
    StDone
  } state_e;

  typedef struct packed {
    logic        [TimeW-1:0] stamp;
    logic signed [TempW-1:0] temp;
  } sample_t;

endpackage

// File: hw/rtl/wsh_store.sv
// ----------------------------------------------------------------------------
// Sample store
// Ring memory of timestamped samples with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module wsh_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  wsh_pkg::sample_t wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output wsh_pkg::sample_t rdata_o
);

  wsh_pkg::sample_t mem_q [DEPTH];
  wsh_pkg::sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/wsh_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wsh_div #(
  parameter int DW = 24,
  parameter int VW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CntW = $clog2(DW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [VW-1:0]   rem_q, rem_d;
  logic [VW-1:0]   div_q, div_d;
  logic [VW:0]     rem_sh;
  logic            fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    fits   = rem_sh >= {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DW);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], fits};
      rem_d = fits ? VW'(rem_sh - {1'b0, div_q}) : VW'(rem_sh);
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: hw/rtl/windowed_sample_history_unit.sv
// ----------------------------------------------------------------------------
// Windowed sample history unit
// Keeps the newest DEPTH timestamped temperature samples and answers window
// queries with the mean and maximum of the samples inside the window.
//
// One item enters on the s_axis channel and gives exactly one item on the
// m_axis channel. An append stores the sample, dropping the oldest one when
// the ring is full; a query walks back from the newest sample while its age
// is within the window, then divides the sum by the sample count.
// An append goes from idle straight to the done state, and its result item is
// loaded into the output register once that register is free. A query walks
// back until an older sample outside the window or the oldest held sample
// ends the walk, reading the samples one after another through the single
// read port of the sample memory; the serial divider then produces the
// quotient one bit at a time, and its result goes through the done state.
// s_axis_tready is high only while the unit is idle, so one item is in work
// at a time. A finished result waits in the output register while the
// receiver stalls, and a new item may be accepted meanwhile.
// Reset empties the history; memory contents are not cleared.
// ----------------------------------------------------------------------------
module windowed_sample_history_unit #(
  parameter int DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sample_time [31:0], sample_temp [47:32], query_window [79:48]
  input  logic [wsh_pkg::InDataW-1:0]   s_axis_tdata,
  // op [0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // sample_count [8:0], latest_time [40:9], latest_temp [56:41],
  // window_average [72:57], window_max [88:73], zero fill [95:89]
  output logic [wsh_pkg::OutDataW-1:0]  m_axis_tdata,
  // has_samples [0]
  output logic                          m_axis_tuser
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int SumW  = wsh_pkg::TempW + CntW;

  wsh_pkg::state_e state_q, state_d;

  logic [CntW-1:0]  held_q, held_d;
  logic [AddrW-1:0] newest_q, newest_d;
  logic [wsh_pkg::TimeW-1:0] latest_time_q, latest_time_d;
  logic signed [wsh_pkg::TempW-1:0] latest_temp_q, latest_temp_d;
  logic [wsh_pkg::TimeW-1:0] window_q, window_d;
  logic [AddrW-1:0] rd_slot_q, rd_slot_d;
  logic [CntW-1:0]  issued_q, issued_d;
  logic [CntW-1:0]  n_q, n_d;
  logic             rd_pend_q, rd_pend_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [wsh_pkg::TempW-1:0] best_q, best_d;
  logic signed [wsh_pkg::TempW-1:0] avg_q, avg_d;
  logic             neg_q, neg_d;
  logic             m_valid_q, m_valid_d;
  logic [wsh_pkg::OutDataW-1:0] m_data_q, m_data_d;
  logic             m_user_q, m_user_d;

  logic             accept;
  logic             is_append;
  logic             issue;
  logic             div_start;
  logic             load_out;
  logic             out_free;
  logic             in_win;
  logic             walk_end;
  logic             wr_en;
  logic [AddrW-1:0] wr_slot;
  logic [AddrW-1:0] next_slot;
  logic [AddrW-1:0] back_slot;
  wsh_pkg::sample_t wr_sample;
  wsh_pkg::sample_t rd_sample;
  logic [wsh_pkg::TimeW-1:0] age;
  logic [SumW-1:0]  dividend;
  logic             div_done;
  logic [SumW-1:0]  quotient;
  logic [wsh_pkg::TempW-1:0] quo_low;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_append = s_axis_tuser == wsh_pkg::OpAppend;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign next_slot = (newest_q == AddrW'(DEPTH - 1)) ? '0 : newest_q + AddrW'(1);
  assign back_slot = (rd_slot_q == '0) ? AddrW'(DEPTH - 1) : rd_slot_q - AddrW'(1);
  assign wr_slot   = (held_q == '0) ? '0 : next_slot;
  assign wr_en     = accept && is_append;
  assign wr_sample.stamp = s_axis_tdata[31:0];
  assign wr_sample.temp  = s_axis_tdata[47:32];
  assign age       = latest_time_q - rd_sample.stamp;
  assign in_win    = age <= window_q;
  assign walk_end  = rd_pend_q && (!in_win || (n_q + CntW'(1)) == held_q);
  assign dividend  = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign quo_low   = quotient[wsh_pkg::TempW-1:0];

  wsh_store #(
    .DEPTH (DEPTH),
    .AW    (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_slot),
    .wdata_i (wr_sample),
    .raddr_i (rd_slot_q),
    .rdata_o (rd_sample)
  );

  wsh_div #(
    .DW (SumW),
    .VW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wsh_pkg::StIdle: begin
        if (accept) begin
          if (!is_append && held_q != '0) begin
            state_d = wsh_pkg::StWalk;
          end else begin
            state_d = wsh_pkg::StDone;
          end
        end
      end
      wsh_pkg::StWalk: begin
        if (walk_end) begin
          state_d = wsh_pkg::StDivStart;
        end
      end
      wsh_pkg::StDivStart: begin
        state_d = wsh_pkg::StDivWait;
      end
      wsh_pkg::StDivWait: begin
        if (div_done) begin
          state_d = wsh_pkg::StDone;
        end
      end
      wsh_pkg::StDone: begin
        if (out_free) begin
          state_d = wsh_pkg::StIdle;
        end
      end
      default: state_d = wsh_pkg::StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready = state_q == wsh_pkg::StIdle;
    issue         = (state_q == wsh_pkg::StWalk) && (issued_q < held_q);
    div_start     = state_q == wsh_pkg::StDivStart;
    load_out      = (state_q == wsh_pkg::StDone) && out_free;
  end

  always_comb begin
    held_d        = held_q;
    newest_d      = newest_q;
    latest_time_d = latest_time_q;
    latest_temp_d = latest_temp_q;
    window_d      = window_q;
    rd_slot_d     = rd_slot_q;
    issued_d      = issued_q;
    n_d           = n_q;
    rd_pend_d     = issue;
    sum_d         = sum_q;
    best_d        = best_q;
    avg_d         = avg_q;
    neg_d         = neg_q;
    if (accept) begin
      window_d  = s_axis_tdata[79:48];
      rd_slot_d = newest_q;
      issued_d  = '0;
      n_d       = '0;
      sum_d     = '0;
      avg_d     = '0;
      best_d    = (!is_append && held_q != '0) ? latest_temp_q : '0;
      if (is_append) begin
        newest_d      = wr_slot;
        latest_time_d = wr_sample.stamp;
        latest_temp_d = wr_sample.temp;
        if (held_q < CntW'(DEPTH)) begin
          held_d = held_q + CntW'(1);
        end
      end
    end
    if (issue) begin
      rd_slot_d = back_slot;
      issued_d  = issued_q + CntW'(1);
    end
    if (state_q == wsh_pkg::StWalk && rd_pend_q && in_win) begin
      sum_d = sum_q + SumW'(rd_sample.temp);
      n_d   = n_q + CntW'(1);
      if (rd_sample.temp > best_q) begin
        best_d = rd_sample.temp;
      end
    end
    if (div_start) begin
      neg_d = sum_q[SumW-1];
    end
    if (state_q == wsh_pkg::StDivWait && div_done) begin
      avg_d = neg_q ? -quo_low : quo_low;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (load_out) begin
      m_valid_d = 1'b1;
      m_data_d  = {7'b0, best_q, avg_q, latest_temp_q, latest_time_q,
                   wsh_pkg::CountW'(held_q)};
      m_user_d  = held_q != '0;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= wsh_pkg::StIdle;
      held_q        <= '0;
      newest_q      <= '0;
      latest_time_q <= '0;
      latest_temp_q <= '0;
      rd_pend_q     <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      held_q        <= held_d;
      newest_q      <= newest_d;
      latest_time_q <= latest_time_d;
      latest_temp_q <= latest_temp_d;
      rd_pend_q     <= rd_pend_d;
      m_valid_q     <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    window_q  <= window_d;
    rd_slot_q <= rd_slot_d;
    issued_q  <= issued_d;
    n_q       <= n_d;
    sum_q     <= sum_d;
    best_q    <= best_d;
    avg_q     <= avg_d;
    neg_q     <= neg_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// File: hw/rtl/wsh_checker.sv
// ----------------------------------------------------------------------------
// Windowed sample history checker
// Port-level assertions for the history unit, bound to its top level.
// ----------------------------------------------------------------------------
module wsh_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [wsh_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tuser
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled output item changed or vanished.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Unit took a second item while the first was in work.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("Result appeared in the cycle after its item was accepted.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("Empty history gave a non-zero result.");

endmodule

bind windowed_sample_history_unit wsh_checker u_wsh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
